[src/tmrf_pkg.sv]
// Shared constants for the tachometer median RPM filter.
// No dependencies; imported by the median selector and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tmrf_pkg;

    // Fixed field widths of the streaming and configuration ports
    localparam int HZ_BITS    = 20;
    localparam int RPM_BITS   = 28;
    localparam int SCALE_BITS = 8;

    // Reset value of the Hz-to-RPM multiplier
    localparam logic [SCALE_BITS-1:0] RPM_SCALE_RESET = 8'd30;

    // Top of the RPM output range; larger products clamp here
    localparam logic [RPM_BITS-1:0] RPM_MAX = 28'd267386625;

endpackage

`default_nettype wire

[src/tmrf_median.sv]
// Combinational median selector over the sample window, by stable ranking.
// Depends on tmrf_pkg; window size and sample width come from parameters.
`timescale 1ns / 1ps
`default_nettype none

module tmrf_median
    import tmrf_pkg::*;
#(
    parameter int WINDOW_SIZE = 5,
    parameter int SAMPLE_BITS = 20
) (
    input  wire logic [SAMPLE_BITS-1:0] win [WINDOW_SIZE],
    output logic      [SAMPLE_BITS-1:0] median
);

    localparam int RANK_BITS = $clog2(WINDOW_SIZE);
    localparam logic [RANK_BITS-1:0] MID_RANK = RANK_BITS'(WINDOW_SIZE / 2);

    logic [RANK_BITS-1:0] rank [WINDOW_SIZE];

    // Rank each entry: entries below it, plus equal entries at lower index
    always_comb begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_SIZE; j++) begin
                if (j != i) begin
                    rank[i] = rank[i] + RANK_BITS'((win[j] < win[i]) ||
                                                   ((j < i) && (win[j] == win[i])));
                end
            end
        end
    end

    // Pick the entry whose rank is the middle position; ranks are unique
    always_comb begin
        median = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            median = median | (win[i] & {SAMPLE_BITS{rank[i] == MID_RANK}});
        end
    end

endmodule

`default_nettype wire

[src/tach_median_rpm_filter_top.sv]
// Top level of the tachometer median RPM filter: ring window, median, scaling.
// Depends on tmrf_pkg and tmrf_median.
// Pipeline: an accepted beat is captured in the input register; its result is then
// registered in the result register, which holds while m_valid is high and m_ready is low.
// Throughput: one beat per cycle; s_ready drops only while the input and result
// registers both hold beats and m_ready is low.
// Reset (aresetn low, synchronous): clears the valids, write slot and fill flag,
// and loads scale_reg with 30; window entries are not reset and are read only once filled.
`timescale 1ns / 1ps
`default_nettype none

module tach_median_rpm_filter_top
    import tmrf_pkg::*;
#(
    parameter int WINDOW_SIZE = 5,
    parameter int SAMPLE_BITS = 20
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [SCALE_BITS-1:0] cfg_wr_data,
    // input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [HZ_BITS-1:0]    s_count_hz,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [HZ_BITS-1:0]    m_filtered_hz,
    output logic      [RPM_BITS-1:0]   m_rpm,
    output logic                       m_window_full
);

    localparam int SLOT_BITS = $clog2(WINDOW_SIZE);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(WINDOW_SIZE - 1);

    logic [SCALE_BITS-1:0]  scale_reg;
    logic [SAMPLE_BITS-1:0] window_reg [WINDOW_SIZE];
    logic [SLOT_BITS-1:0]   slot_reg, slot_next;
    logic                   filled_reg, filled_next;

    logic                   a_valid_reg, a_valid_next;
    logic [SAMPLE_BITS-1:0] a_sample_reg;
    logic                   a_full_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [HZ_BITS-1:0]     m_filt_reg;
    logic [RPM_BITS-1:0]    m_rpm_reg;
    logic                   m_full_reg;

    logic                   out_adv, a_free, accept;
    logic [SAMPLE_BITS-1:0] sample_in;
    logic [SAMPLE_BITS-1:0] median;
    logic [HZ_BITS-1:0]     filt_a;
    logic [RPM_BITS-1:0]    product, rpm_sat;

    // Flow: the input register moves when the result register is empty or moving
    assign out_adv = !m_valid_reg || m_ready;
    assign a_free  = !a_valid_reg || out_adv;
    assign s_ready = a_free;
    assign accept  = s_valid && a_free;

    always_comb begin
        a_valid_next = a_valid_reg;
        m_valid_next = m_valid_reg;
        if (a_free) begin
            a_valid_next = s_valid;
        end
        if (out_adv) begin
            m_valid_next = a_valid_reg;
        end
    end

    // Advance the write slot with wrap; latch the fill flag on wrap
    assign sample_in = SAMPLE_BITS'(s_count_hz);

    always_comb begin
        slot_next   = slot_reg;
        filled_next = filled_reg;
        if (accept) begin
            if (slot_reg == LAST_SLOT) begin
                slot_next   = '0;
                filled_next = 1'b1;
            end else begin
                slot_next = slot_reg + SLOT_BITS'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg   <= RPM_SCALE_RESET;
            slot_reg    <= '0;
            filled_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                scale_reg <= cfg_wr_data;
            end
            slot_reg    <= slot_next;
            filled_reg  <= filled_next;
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Window write and input stage capture on an accepted beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            window_reg[slot_reg] <= sample_in;
            a_sample_reg         <= sample_in;
            a_full_reg           <= filled_next;
        end
    end

    // Median over the window as it stands after this beat's write
    tmrf_median #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .win    (window_reg),
        .median (median)
    );

    assign filt_a = a_full_reg ? HZ_BITS'(median) : HZ_BITS'(a_sample_reg);

    // Scale to RPM and clamp at range top
    assign product = RPM_BITS'(filt_a) * RPM_BITS'(scale_reg);
    assign rpm_sat = (product > RPM_MAX) ? RPM_MAX : product;

    // Result register
    always_ff @(posedge aclk) begin
        if (out_adv) begin
            m_filt_reg <= filt_a;
            m_rpm_reg  <= rpm_sat;
            m_full_reg <= a_full_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_filtered_hz = m_filt_reg;
    assign m_rpm         = m_rpm_reg;
    assign m_window_full = m_full_reg;

    // Checks
    a_filled_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg |=> filled_reg)
        else $error("fill flag dropped after being set");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= LAST_SLOT)
        else $error("write slot beyond window");

    a_wrap_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (slot_reg == LAST_SLOT)) |=> (filled_reg && (slot_reg == '0)))
        else $error("slot wrap did not set fill flag");

    a_stall_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (a_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled with room in pipeline");

    a_rpm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_rpm_reg <= RPM_MAX))
        else $error("rpm beyond range");

endmodule

`default_nettype wire
